@@ rtl/erm_pkg.sv @@
// ============================================================================
// erm_pkg - event rate meter shared definitions
// Field widths, beat packing and fixed constants of the event rate meter.
// ============================================================================
package erm_pkg;

    // Input beat fields
    localparam int SEC_W      = 32;
    localparam int USEC_W     = 20;
    localparam int S_TDATA_W  = 56;     // sec + usec, padded to bytes

    // Result beat fields
    localparam int HZ_W       = 10;
    localparam int M_TDATA_W  = 24;     // latest + average, padded to bytes
    localparam int M_PAD_W    = M_TDATA_W - 2 * HZ_W;

    // Millisecond time base
    localparam int TIME_W     = 42;
    localparam int MS_PER_SEC = 1000;
    localparam int US_PER_MS  = 1000;
    localparam int RATE_NUM   = 1000;   // rate = RATE_NUM / delta_ms
    localparam int HZ_MAX     = 1000;

endpackage

@@ rtl/erm_ram.sv @@
// ============================================================================
// erm_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module erm_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/erm_div.sv @@
// ============================================================================
// erm_div - iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses when finished.
// ============================================================================
module erm_div #(
    parameter int W = 20
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);

    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     dvs_reg;

    logic [W:0]       rem_sh;
    logic [W:0]       rem_sub;
    logic             ge;

    // shift in next dividend bit, trial subtract
    assign rem_sh  = {rem_reg, quo_reg[W-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign ge      = (rem_sh >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
            quo_reg <= {quo_reg[W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/event_rate_meter_core.sv @@
// ============================================================================
// event_rate_meter_core - event rate meter with moving average
// Turns timestamped events into a per-event rate (1000 / delta ms) and a
// running average over the last RING_DEPTH rates.
// ============================================================================
//
//  channel   dir  signals                         fields (lowest bit up)
//  -------   ---  ------------------------------  ------------------------------
//  s_axis    in   s_tvalid s_tready s_tdata        tdata: time_sec[31:0],
//                 s_tuser                                 time_usec[51:32], pad
//                                                 tuser: is_relative
//  m_axis    out  m_tvalid m_tready m_tdata        tdata: latest_hz[9:0],
//                                                         average_hz[19:10], pad
//
//  Sequencing: a relative event that yields a rate holds the input until its
//  result is parked, through three passes of the one bit-per-cycle divider:
//  usec / 1000, 1000 / delta, ring sum / sample count. A relative event with
//  no result frees the input after the first pass and the time compare; a
//  non-relative beat is dropped in the cycle it is taken.
//  s_tready is high only while the sequencer is idle; one finished result may
//  wait in the output register while the next event is being worked on, and
//  a stalled receiver holds the sequencer in its last state after that.
//  Reset: asynchronous, clears all control state. The rate ring needs no
//  clearing pass: slots are written in order, so the sample count tells
//  whether the slot being replaced holds a real rate or is still unwritten.
//
module event_rate_meter_core #(
    parameter int RING_DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [erm_pkg::S_TDATA_W-1:0] s_tdata,  // time_sec, time_usec, pad
    input  logic                          s_tuser,  // is_relative

    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [erm_pkg::M_TDATA_W-1:0] m_tdata   // latest_hz, average_hz, pad
);

    import erm_pkg::*;

    // ring bookkeeping widths
    localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int SUM_W  = $clog2(RING_DEPTH * HZ_MAX + 1);
    localparam int DIV_W  = (SUM_W > USEC_W) ? SUM_W : USEC_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_USEC,     // usec / 1000 in the divider
        S_CMP,      // compare with previous time, launch rate divide
        S_RATE,     // 1000 / delta in the divider, then ring update
        S_AVG,      // sum / count in the divider
        S_OUT       // park result into the output register
    } state_t;

    state_t              state_reg;
    logic [TIME_W-1:0]   sec_ms_reg;
    logic [TIME_W-1:0]   t_reg;
    logic [TIME_W-1:0]   prev_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic                full_reg;      // slot being replaced held a rate
    logic [HZ_W-1:0]     rate_reg;
    logic [HZ_W-1:0]     avg_reg;
    logic [HZ_W-1:0]     latest_out_reg;
    logic [HZ_W-1:0]     avg_out_reg;
    logic                m_tvalid_reg;

    logic                s_beat;
    logic [SEC_W-1:0]    in_sec;
    logic [USEC_W-1:0]   in_usec;
    logic [TIME_W-1:0]   delta;
    logic                rate_ok;
    logic [SLOT_W-1:0]   slot_next;
    logic [CNT_W-1:0]    count_next;
    logic [SUM_W-1:0]    old_rate;
    logic [SUM_W-1:0]    sum_next;
    logic [HZ_W-1:0]     ring_rdata;
    logic                ring_we;
    logic                out_load;

    logic                div_start;
    logic [DIV_W-1:0]    div_dividend;
    logic [DIV_W-1:0]    div_divisor;
    logic                div_done;
    logic [DIV_W-1:0]    div_q;

    assign s_tready = (state_reg == S_IDLE);
    assign s_beat   = s_tvalid && s_tready;
    assign in_sec   = s_tdata[SEC_W-1:0];
    assign in_usec  = s_tdata[SEC_W +: USEC_W];

    // delta only used when t_reg > prev_reg
    assign delta    = t_reg - prev_reg;
    assign rate_ok  = (t_reg > prev_reg) && (delta <= TIME_W'(RATE_NUM));

    assign slot_next  = (slot_reg == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_reg + SLOT_W'(1);
    assign count_next = (count_reg == CNT_W'(RING_DEPTH)) ? count_reg
                                                         : count_reg + CNT_W'(1);

    // ring update: sum - replaced + new
    assign old_rate = full_reg ? SUM_W'(ring_rdata) : '0;
    assign sum_next = sum_reg - old_rate + SUM_W'(div_q[HZ_W-1:0]);
    assign ring_we  = (state_reg == S_RATE) && div_done;

    // output register free or draining this cycle
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    // divider operand select
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = DIV_W'(RATE_NUM);
        div_divisor  = DIV_W'(US_PER_MS);
        case (state_reg)
            S_IDLE:
            begin
                div_start    = s_beat && s_tuser;
                div_dividend = DIV_W'(in_usec);
                div_divisor  = DIV_W'(US_PER_MS);
            end
            S_CMP:
            begin
                div_start    = rate_ok;
                div_dividend = DIV_W'(RATE_NUM);
                div_divisor  = DIV_W'(delta[HZ_W:0]);
            end
            S_RATE:
            begin
                div_start    = div_done;
                div_dividend = DIV_W'(sum_next);
                div_divisor  = DIV_W'(count_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    erm_div #(
        .W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    erm_ram #(
        .WIDTH (HZ_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (slot_reg),
        .wdata (div_q[HZ_W-1:0]),
        .re    (state_reg == S_CMP),
        .raddr (slot_next),
        .rdata (ring_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            sec_ms_reg     <= '0;
            t_reg          <= '0;
            prev_reg       <= '0;
            slot_reg       <= '0;
            count_reg      <= '0;
            sum_reg        <= '0;
            full_reg       <= 1'b0;
            rate_reg       <= '0;
            avg_reg        <= '0;
            latest_out_reg <= '0;
            avg_out_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_beat && s_tuser)
                    begin
                        sec_ms_reg <= {{(TIME_W - SEC_W){1'b0}}, in_sec}
                                      * TIME_W'(MS_PER_SEC);
                        state_reg  <= S_USEC;
                    end
                end
                S_USEC:
                begin
                    if (div_done)
                    begin
                        t_reg     <= sec_ms_reg + TIME_W'(div_q);
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    // equal time: nothing changes
                    if (t_reg != prev_reg)
                    begin
                        prev_reg <= t_reg;
                    end
                    if (rate_ok)
                    begin
                        full_reg  <= (count_reg == CNT_W'(RING_DEPTH));
                        count_reg <= count_next;
                        slot_reg  <= slot_next;
                        state_reg <= S_RATE;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_RATE:
                begin
                    if (div_done)
                    begin
                        rate_reg  <= div_q[HZ_W-1:0];
                        sum_reg   <= sum_next;
                        state_reg <= S_AVG;
                    end
                end
                S_AVG:
                begin
                    if (div_done)
                    begin
                        avg_reg   <= div_q[HZ_W-1:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    // wait for the previous result to drain
                    if (out_load)
                    begin
                        latest_out_reg <= rate_reg;
                        avg_out_reg    <= avg_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, avg_out_reg, latest_out_reg};

endmodule

@@ rtl/erm_checker.sv @@
// ============================================================================
// erm_checker - port-level checks for the event rate meter
// Watches the stream ports of event_rate_meter_core; bound to the top level.
// ============================================================================
module erm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [erm_pkg::M_TDATA_W-1:0] m_tdata
);

    import erm_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a relative event keeps the sequencer busy
    a_busy_after_event: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("input ready right after a relative event");

    a_latest_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[HZ_W-1:0] != '0) && (m_tdata[HZ_W-1:0] <= HZ_W'(HZ_MAX)))
        else $error("latest rate out of range");

    a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2*HZ_W-1:HZ_W] <= HZ_W'(HZ_MAX)))
        else $error("average rate out of range");

endmodule

bind event_rate_meter_core erm_checker u_erm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/sv/event_rate_meter_core_test.sv @@
// ============================================================================
// event_rate_meter_core_test - self-checking bench for the event rate meter
// A stimulus table walks the corner cases first: ignored events, equal times,
// time going backwards, gaps over a second, out-of-range usec and the largest
// timestamps. A random run of timed event streams follows. A local model of
// the meter predicts every rate/average beat, and each beat is checked in
// order while both stream sides idle and stall at random.
// ============================================================================
module event_rate_meter_core_test;
    import erm_pkg::*;

    localparam int RING_DEPTH    = 64;
    localparam int RANDOM_EVENTS = 400;     // relative events in the random run
    localparam int LONG_HOLD     = 3000;    // cycles of receiver hold-off
    localparam int DRAIN_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 300;     // idle time after the last drain, to catch extra beats

    typedef logic [TIME_W-1:0] ms_t;
    typedef logic [HZ_W-1:0]   hz_t;

    // One result beat: the rate of the latest interval and the ring average
    typedef struct packed {
        hz_t latest;
        hz_t average;
    } rate_beat_t;

    // One row of the directed table; known = the result is typed in here
    typedef struct packed {
        logic        rel;
        logic [31:0] sec;
        logic [19:0] usec;
        logic        known;
        logic        gives;
        hz_t         latest;
        hz_t         average;
    } event_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    event_rate_meter_core #(
        .RING_DEPTH (RING_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // time_sec, time_usec, pad
        .s_tuser  (s_tuser),    // is_relative
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // latest_hz, average_hz, pad
    );

    // ------------------------------------------------------------------------
    // Meter model: last event time, rate ring with running sum and count
    // ------------------------------------------------------------------------
    ms_t         last_ms;
    hz_t         rate_hist [RING_DEPTH];
    logic [5:0]  hist_slot;
    logic [6:0]  hist_count;
    logic [15:0] hist_sum;

    rate_beat_t  expected_rates [$];

    int unsigned mismatch_count;
    int unsigned events_sent;
    int unsigned relative_sent;
    int unsigned rates_checked;
    int unsigned burst_left;
    bit          hold_request;      // asks the receiver for its long hold-off
    longint unsigned stim_ms;       // time base of the random event stream

    function automatic void clear_meter_model();
        last_ms    = '0;
        hist_slot  = '0;
        hist_count = '0;
        hist_sum   = '0;
        foreach (rate_hist[i])
            rate_hist[i] = '0;
    endfunction

    // Applies one event to the model; returns 1 when the event yields a beat.
    function automatic bit meter_event(input logic rel, input logic [31:0] sec,
                                       input logic [19:0] usec,
                                       output rate_beat_t beat);
        ms_t now_ms;
        ms_t delta;
        hz_t rate;
        beat = '0;
        if (!rel)
            return 1'b0;
        // 32-bit seconds times 1000 plus at most 1048 ms always fits 42 bits
        now_ms = ms_t'(sec) * ms_t'(MS_PER_SEC) + ms_t'(usec) / ms_t'(US_PER_MS);
        if (now_ms == last_ms)
            return 1'b0;                    // zero interval: nothing changes
        if (now_ms < last_ms)
        begin
            last_ms = now_ms;               // backwards: only the time moves
            return 1'b0;
        end
        delta   = now_ms - last_ms;
        last_ms = now_ms;
        if (delta > ms_t'(RATE_NUM))
            return 1'b0;                    // under 1 Hz truncates to zero
        rate = hz_t'(ms_t'(RATE_NUM) / delta);
        if (hist_count < RING_DEPTH)
            hist_count = hist_count + 1'b1;
        hist_slot = (hist_slot == RING_DEPTH - 1) ? '0 : hist_slot + 1'b1;
        hist_sum  = hist_sum - 16'(rate_hist[hist_slot]) + 16'(rate);
        rate_hist[hist_slot] = rate;
        beat.latest  = rate;
        beat.average = hz_t'(hist_sum / 16'(hist_count));
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH %s: expected %0d, got %0d (t=%0t)", what, want, got,
                     $realtime);
    endtask

    // ------------------------------------------------------------------------
    // Directed table, run right after reset. Typed results hold only where
    // the arithmetic is trivial; the other rows go through the model.
    // ------------------------------------------------------------------------
    event_row_t directed_events [17] = '{
        // ignored event with every data bit set
        '{1'b0, 32'hFFFF_FFFF, 20'hF_FFFF, 1'b1, 1'b0, 10'd0,    10'd0},
        // t = 0 equals the reset time: zero interval
        '{1'b1, 32'd0,         20'd0,      1'b1, 1'b0, 10'd0,    10'd0},
        // 1 ms after reset: 1000 Hz, one sample
        '{1'b1, 32'd0,         20'd1000,   1'b1, 1'b1, 10'd1000, 10'd1000},
        // same millisecond, different usec: zero interval
        '{1'b1, 32'd0,         20'd1999,   1'b1, 1'b0, 10'd0,    10'd0},
        // 3 ms, 2 ms later: 500 Hz, average (1000 + 500) / 2
        '{1'b1, 32'd0,         20'd3000,   1'b1, 1'b1, 10'd500,  10'd750},
        // exactly one second: 1 Hz, average 1501 / 3
        '{1'b1, 32'd1,         20'd3000,   1'b1, 1'b1, 10'd1,    10'd500},
        // 1001 ms gap: rate truncates to zero
        '{1'b1, 32'd2,         20'd4000,   1'b1, 1'b0, 10'd0,    10'd0},
        // time goes backwards
        '{1'b1, 32'd2,         20'd0,      1'b1, 1'b0, 10'd0,    10'd0},
        // equal to the time left by the backwards step
        '{1'b1, 32'd2,         20'd3,      1'b1, 1'b0, 10'd0,    10'd0},
        '{1'b1, 32'd2,         20'd7000,   1'b0, 1'b0, 10'd0,    10'd0},
        // usec at its field maximum, beyond one second
        '{1'b1, 32'd2,         20'hF_FFFF, 1'b0, 1'b0, 10'd0,    10'd0},
        '{1'b1, 32'd3,         20'd49575,  1'b0, 1'b0, 10'd0,    10'd0},
        '{1'b0, 32'd3,         20'd50000,  1'b0, 1'b0, 10'd0,    10'd0},
        // largest seconds value
        '{1'b1, 32'hFFFF_FFFF, 20'd999999, 1'b0, 1'b0, 10'd0,    10'd0},
        // largest time the fields can express
        '{1'b1, 32'hFFFF_FFFF, 20'hF_FFFF, 1'b0, 1'b0, 10'd0,    10'd0},
        // wrap back to zero from the top
        '{1'b1, 32'd0,         20'd0,      1'b0, 1'b0, 10'd0,    10'd0},
        '{1'b1, 32'd0,         20'd333000, 1'b0, 1'b0, 10'd0,    10'd0}
    };

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Sender: holds one event until the beat is taken, then books the
    // predicted result. Inputs are sampled right after the edge, before any
    // flop in the block updates, so the handshake seen is the one at the edge.
    // ------------------------------------------------------------------------
    task automatic offer_event(input logic rel, input logic [31:0] sec,
                               input logic [19:0] usec, input logic known,
                               input logic gives, input rate_beat_t typed_beat);
        rate_beat_t beat;
        bit         has_beat;
        s_tvalid <= 1'b1;
        s_tuser  <= rel;
        s_tdata  <= {{(S_TDATA_W - SEC_W - USEC_W){1'b0}}, usec, sec};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        has_beat = meter_event(rel, sec, usec, beat);
        if (known)
        begin
            has_beat = gives;
            beat     = typed_beat;
        end
        if (has_beat)
            expected_rates.push_back(beat);
        events_sent++;
        if (rel)
            relative_sent++;
    endtask

    // Bursts of back-to-back beats split by idle gaps of random length
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 15);
        case ($urandom_range(0, 3))
            0:       gap = 0;
            1:       gap = $urandom_range(40, 150);
            default: gap = $urandom_range(1, 12);
        endcase
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending until every booked result has come out
    task automatic drain_rates();
        int unsigned n;
        s_tvalid <= 1'b0;
        @(posedge clk);
        for (n = 0; n < DRAIN_LIMIT && expected_rates.size() != 0; n++)
            @(posedge clk);
    endtask

    // Next event of the random stream. Mostly forward steps of a running
    // clock so the ring fills and wraps; the rest hits the no-result cases
    // and ignored beats with random content.
    task automatic pick_event(output logic rel, output logic [31:0] sec,
                              output logic [19:0] usec);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        rel  = 1'b1;
        if (pick >= 84 && pick < 92)
        begin
            rel  = 1'b0;
            sec  = $urandom;
            usec = 20'($urandom_range(0, 20'hF_FFFF));
            return;
        end
        if (pick >= 92)
        begin
            // anywhere in the time range, usec possibly out of range
            sec     = $urandom;
            usec    = 20'($urandom_range(0, 20'hF_FFFF));
            stim_ms = longint'(sec) * 1000 + usec / 1000;
            return;
        end
        if (pick < 30)
            stim_ms += $urandom_range(1, 10);         // fast events
        else if (pick < 65)
            stim_ms += $urandom_range(1, 1000);       // anything from 1 Hz up
        else if (pick < 72)
            ;                                         // same millisecond
        else if (pick < 78)
            stim_ms -= (stim_ms > 5000) ? $urandom_range(1, 5000) : stim_ms;
        else
            stim_ms += $urandom_range(1001, 200000);  // gap over a second
        if (stim_ms / 1000 > 64'hFFFF_FFFF)
            stim_ms = stim_ms % 1000;
        sec  = 32'(stim_ms / 1000);
        usec = 20'((stim_ms % 1000) * 1000 + $urandom_range(0, 999));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic        rel;
        logic [31:0] sec;
        logic [19:0] usec;
        rst_n          <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tuser        <= 1'b0;
        mismatch_count = 0;
        events_sent    = 0;
        relative_sent  = 0;
        rates_checked  = 0;
        burst_left     = 0;
        stim_ms        = 0;
        clear_meter_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_events[i])
        begin
            offer_event(directed_events[i].rel, directed_events[i].sec,
                        directed_events[i].usec, directed_events[i].known,
                        directed_events[i].gives,
                        {directed_events[i].latest, directed_events[i].average});
            pace_sender();
        end
        drain_rates();

        // Restart the stream time near the model's last time so that the
        // random run begins with valid rates
        stim_ms = last_ms;
        relative_sent = 0;
        while (relative_sent < RANDOM_EVENTS)
        begin
            // receiver goes dark for a long stretch while we keep offering
            if (relative_sent == 120)
                hold_request = 1'b1;
            pick_event(rel, sec, usec);
            offer_event(rel, sec, usec, 1'b0, 1'b0, '0);
            if (rel && relative_sent == 300)
                drain_rates();
            else
                pace_sender();
        end

        // Wind down: every booked beat must come out, and no more after it
        drain_rates();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_rates.size() != 0)
            report_mismatch("results never delivered", 0, expected_rates.size());

        $display("Covered %0d events (%0d directed), %0d rate beats checked,",
                 events_sent, $size(directed_events), rates_checked);
        $display("ring wraps, count saturation, ignored and no-result events, stalls.");
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: stall patterns that change after a random span, plus the
    // long hold-off that backs the block up into its input side
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int unsigned mode;
        int unsigned span;
        int unsigned n;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 300);
            for (n = 0; n < span && !hold_request; n++)
            begin
                case (mode)
                    0:       m_tready <= 1'b1;                          // no stalls
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 9) != 0);
                    default: m_tready <= n[3];                          // square wave
                endcase
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result check: each beat against the oldest booked prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        rate_beat_t got;
        rate_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.latest  = m_tdata[HZ_W-1:0];
            got.average = m_tdata[2*HZ_W-1:HZ_W];
            if (expected_rates.size() == 0)
                report_mismatch("beat with no prediction, latest_hz", 0, got.latest);
            else
            begin
                want = expected_rates.pop_front();
                rates_checked++;
                if (got.latest !== want.latest)
                    report_mismatch("latest_hz", want.latest, got.latest);
                if (got.average !== want.average)
                    report_mismatch("average_hz", want.average, got.average);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        #10000000;
        $display("Timeout: run did not finish");
        $display("Test completed with failures");
        $finish;
    end

endmodule
